[rtl/assert_macros.svh]
// Assertion macros used by the classifier top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication property on the rising clock edge outside reset.
`define DPC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds on the rising clock edge outside reset.
`define DPC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/dpc_pkg.sv]
// Package with the constants and item types of the digraph property classifier.
package dpc_pkg;

  localparam int MaxVertices = 64;
  localparam int VIdxW = $clog2(MaxVertices);
  localparam int CntW = VIdxW + 1;

  typedef struct packed {
    logic edge_present;
    logic last_entry;
  } in_item_t;

  typedef struct packed {
    logic is_regular;
    logic is_balanced;
    logic is_strongly_connected;
    logic is_weakly_connected;
    logic is_eulerian;
  } out_item_t;

endpackage

[rtl/dpc_ram.sv]
// Generic single-write, single-read RAM with a registered read.
module dpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/digraph_property_classifier.sv]
// Top level of the digraph property classifier.
//
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_item (edge_present, last_entry)
// out     | output    | out_valid/out_stall| out_item (five flags)
// cfg     | input     | cfg_we             | cfg_data (vertex count)
//
// Each matrix entry is handled in two steps: a read of its row and column words, then
// the write back through the row and column memory ports; the next entry waits on in_stall.
// After the last entry the block walks all n rows per pass, one per cycle.
// The first pass also counts degrees; passes repeat until a pass after the first changes
// no reach set, and then ST_FIN loads the result once the output register is free.
// Reset is synchronous; no clearing pass is needed, as unwritten entries are
// never read in a complete load.
// A result held by out_stall holds the next evaluation in ST_FIN; it does not block loading.
module digraph_property_classifier
  import dpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [CntW-1:0] cfg_data
);

`include "assert_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LD_WR = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state;
  logic [CntW-1:0] vc;
  logic [CntW-1:0] n;
  logic [MaxVertices-1:0] mask;
  logic [VIdxW-1:0] r, c, lr, lc;
  logic ld_edge, ld_last;
  logic [CntW-1:0] ai;
  logic pv;
  logic [VIdxW-1:0] pi;
  logic first;
  logic chg_any;
  logic [MaxVertices-1:0] fwd, bwd, und, eul, active;
  logic anye, regf, balf, evenf;
  logic [CntW-1:0] in0, out0;

  logic [MaxVertices-1:0] row_rd, col_rd, row_wr, col_wr;
  logic [VIdxW-1:0] row_ra, col_ra;
  logic mem_we;
  logic accept;

  logic [MaxVertices-1:0] row_m, col_m;
  logic [MaxVertices-1:0] fwd_next, bwd_next, und_next, eul_next, active_next;
  logic [CntW-1:0] outdeg, indeg, in_ref, out_ref;
  logic pe, chg;

  always_comb begin
    n = vc;
    if (vc == '0) begin
      n = CntW'(1);
    end else if (vc > CntW'(MaxVertices)) begin
      n = CntW'(MaxVertices);
    end
    if (n == CntW'(MaxVertices)) begin
      mask = '1;
    end else begin
      mask = (MaxVertices'(1) << n) - MaxVertices'(1);
    end
  end

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    row_ra = r;
    col_ra = c;
    if (state == ST_EVAL) begin
      row_ra = ai[VIdxW-1:0];
      col_ra = ai[VIdxW-1:0];
    end
    row_wr = row_rd;
    col_wr = col_rd;
    row_wr[lc] = ld_edge;
    col_wr[lr] = ld_edge;
    mem_we = (state == ST_LD_WR);
  end

  dpc_ram #(.Width(MaxVertices), .Depth(MaxVertices)) u_rows (
    .clk(clk), .we(mem_we), .waddr(lr), .wdata(row_wr), .raddr(row_ra), .rdata(row_rd)
  );

  dpc_ram #(.Width(MaxVertices), .Depth(MaxVertices)) u_cols (
    .clk(clk), .we(mem_we), .waddr(lc), .wdata(col_wr), .raddr(col_ra), .rdata(col_rd)
  );

  always_comb begin
    row_m = row_rd & mask;
    col_m = col_rd & mask;
    outdeg = CntW'($countones(row_m));
    indeg = CntW'($countones(col_m));
    in_ref = (pi == '0) ? indeg : in0;
    out_ref = (pi == '0) ? outdeg : out0;
    fwd_next = fwd;
    bwd_next = bwd;
    und_next = und;
    eul_next = eul;
    active_next = active;
    if (pv) begin
      if (fwd[pi]) fwd_next = fwd | row_m;
      if (bwd[pi]) bwd_next = bwd | col_m;
      if (und[pi]) und_next = und | row_m | col_m;
      if (!first && eul[pi]) eul_next = eul | row_m | col_m;
      if (first && (outdeg != '0 || indeg != '0)) active_next[pi] = 1'b1;
    end
    chg = (fwd_next != fwd) || (bwd_next != bwd) || (und_next != und)
       || (eul_next != eul);
    pe = pv && ({1'b0, pi} == n - CntW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vc <= CntW'(1);
      r <= '0;
      c <= '0;
      out_valid <= 1'b0;
      pv <= 1'b0;
      ai <= '0;
      first <= 1'b0;
      chg_any <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        vc <= cfg_data;
        r <= '0;
        c <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ld_edge <= in_item.edge_present;
            ld_last <= in_item.last_entry;
            lr <= r;
            lc <= c;
            if (in_item.last_entry) begin
              r <= '0;
              c <= '0;
            end else if ({1'b0, c} == n - CntW'(1)) begin
              c <= '0;
              r <= ({1'b0, r} == n - CntW'(1)) ? '0 : r + VIdxW'(1);
            end else begin
              c <= c + VIdxW'(1);
            end
            state <= ST_LD_WR;
          end
        end
        ST_LD_WR: begin
          if (ld_last) begin
            ai <= '0;
            pv <= 1'b0;
            first <= 1'b1;
            chg_any <= 1'b0;
            fwd <= MaxVertices'(1);
            bwd <= MaxVertices'(1);
            und <= MaxVertices'(1);
            eul <= '0;
            active <= '0;
            anye <= 1'b0;
            regf <= 1'b1;
            balf <= 1'b1;
            evenf <= 1'b1;
            state <= ST_EVAL;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EVAL: begin
          pv <= (ai < n);
          pi <= ai[VIdxW-1:0];
          if (ai < n) begin
            ai <= ai + CntW'(1);
          end
          fwd <= fwd_next;
          bwd <= bwd_next;
          und <= und_next;
          eul <= eul_next;
          active <= active_next;
          if (chg) chg_any <= 1'b1;
          if (pv && first) begin
            if (pi == '0) begin
              in0 <= indeg;
              out0 <= outdeg;
            end
            if (outdeg != '0) anye <= 1'b1;
            if (indeg != in_ref || outdeg != out_ref) regf <= 1'b0;
            if (indeg != outdeg) balf <= 1'b0;
            if (indeg[0] ^ outdeg[0]) evenf <= 1'b0;
          end
          if (pe) begin
            pv <= 1'b0;
            if (first) begin
              eul <= active_next & (~active_next + MaxVertices'(1));
            end
            if (first || chg || chg_any) begin
              ai <= '0;
              first <= 1'b0;
              chg_any <= 1'b0;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_item.is_regular <= anye && regf;
            out_item.is_balanced <= anye && balf;
            out_item.is_strongly_connected <= (fwd == mask) && (bwd == mask);
            out_item.is_weakly_connected <= !((fwd == mask) && (bwd == mask))
                                            && (und == mask);
            out_item.is_eulerian <= anye && evenf && ((active & ~eul) == '0);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `DPC_CHECK(a_fin_loads, (state == ST_FIN && !out_valid) |=> out_valid, "result not loaded")
  `DPC_NEVER(a_pi_range, pv && ({1'b0, pi} >= n), "walk index beyond vertex count")
  `DPC_CHECK(a_wr_once, (state == ST_LD_WR) |=> (state != ST_LD_WR), "write back repeated")

endmodule

[tb/sv/digraph_property_classifier_tb.sv]
// Self-checking testbench for the digraph property classifier with a graph predictor.
module digraph_property_classifier_tb
  import dpc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CntW-1:0] cfg_data = '0;

  digraph_property_classifier u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [63:0] graph_rows [MaxVertices];
  logic [63:0] graph_cols [MaxVertices];
  int unsigned vertices = 1;
  int unsigned entry_pos = 0;
  out_item_t pending_flags [$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit stall_mode_random = 1'b1;
  bit tail_phase = 1'b0;

  function automatic int unsigned eff_vertices(logic [CntW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxVertices) return MaxVertices;
    return v;
  endfunction

  function automatic logic [63:0] reach_from(int unsigned start, logic [63:0] mask,
                                             bit fwd, bit bwd);
    logic [63:0] set;
    logic [63:0] prev;
    set = 64'd1 << start;
    prev = '0;
    while (set != prev) begin
      prev = set;
      for (int i = 0; i < vertices; i++) begin
        if (prev[i]) begin
          if (fwd) set |= graph_rows[i] & mask;
          if (bwd) set |= graph_cols[i] & mask;
        end
      end
    end
    return set;
  endfunction

  function automatic out_item_t classify_graph();
    out_item_t f;
    logic [63:0] mask;
    logic [63:0] active;
    logic [63:0] undirected;
    int unsigned indeg [MaxVertices];
    int unsigned outdeg [MaxVertices];
    bit any;
    int unsigned s;
    mask = (vertices >= 64) ? '1 : ((64'd1 << vertices) - 1);
    any = 1'b0;
    active = '0;
    for (int i = 0; i < vertices; i++) begin
      outdeg[i] = $countones(graph_rows[i] & mask);
      indeg[i] = $countones(graph_cols[i] & mask);
      if (outdeg[i] != 0) any = 1'b1;
      if (outdeg[i] + indeg[i] != 0) active[i] = 1'b1;
    end
    f.is_regular = any;
    f.is_balanced = any;
    f.is_eulerian = any;
    for (int i = 0; i < vertices; i++) begin
      if (indeg[i] != indeg[0] || outdeg[i] != outdeg[0]) f.is_regular = 1'b0;
      if (indeg[i] != outdeg[i]) f.is_balanced = 1'b0;
      if ((indeg[i] + outdeg[i]) % 2 != 0) f.is_eulerian = 1'b0;
    end
    f.is_strongly_connected = (reach_from(0, mask, 1, 0) == mask) &&
                              (reach_from(0, mask, 0, 1) == mask);
    undirected = reach_from(0, mask, 1, 1);
    f.is_weakly_connected = !f.is_strongly_connected && (undirected == mask);
    if (f.is_eulerian) begin
      s = 0;
      while (s < vertices && !active[s]) s++;
      if (s < vertices && (active & ~reach_from(s, mask, 1, 1)) != 0) f.is_eulerian = 1'b0;
    end
    return f;
  endfunction

  function automatic void record_entry(in_item_t it);
    int unsigned r;
    int unsigned c;
    if (entry_pos >= vertices * vertices) entry_pos = 0;
    r = entry_pos / vertices;
    c = entry_pos % vertices;
    graph_rows[r][c] = it.edge_present;
    graph_cols[c][r] = it.edge_present;
    entry_pos++;
    if (entry_pos >= vertices * vertices) entry_pos = 0;
    if (it.last_entry) begin
      entry_pos = 0;
      pending_flags.push_back(classify_graph());
    end
  endfunction

  task automatic random_gap(int unsigned long_pct);
    int unsigned n;
    if ($urandom_range(99) < 40) return;
    n = ($urandom_range(99) < long_pct) ? $urandom_range(60, 10) : $urandom_range(3, 1);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_entry(bit e, bit last, int unsigned gap_pct);
    in_item_t it;
    it.edge_present = e;
    it.last_entry = last;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    record_entry(it);
    in_valid <= 1'b0;
    @(posedge clk);
    if (gap_pct != 0) random_gap(gap_pct);
  endtask

  task automatic wait_drained();
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (4 * 66 * 66) @(posedge clk);
  endtask

  task automatic set_vertices(int unsigned v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= CntW'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    vertices = eff_vertices(CntW'(v));
    entry_pos = 0;
  endtask

  // Sends a whole matrix; density is the chance per entry of an edge, in percent.
  task automatic send_matrix(int unsigned density, int unsigned gap_pct);
    int unsigned total;
    total = vertices * vertices;
    for (int k = 0; k < total; k++)
      send_entry($urandom_range(99) < density, k == total - 1, gap_pct);
  endtask

  // Sends a matrix built from a row mask function given by kind.
  task automatic send_pattern(int kind);
    bit e;
    int unsigned r;
    int unsigned c;
    for (int k = 0; k < vertices * vertices; k++) begin
      r = k / vertices;
      c = k % vertices;
      case (kind)
        0: e = 1'b0;
        1: e = 1'b1;
        2: e = (c == (r + 1) % vertices);
        3: e = (c == r + 1);
        4: e = (c == r + 1) || (r == c + 1);
        default: e = (r == c);
      endcase
      send_entry(e, k == vertices * vertices - 1, 0);
    end
  endtask

  task automatic test_directed();
    set_vertices(1);
    send_entry(1'b0, 1'b1, 0);
    send_entry(1'b1, 1'b1, 0);
    set_vertices(0);
    send_entry(1'b1, 1'b1, 0);
    set_vertices(3);
    for (int kind = 0; kind < 6; kind++) send_pattern(kind);
    set_vertices(4);
    send_pattern(2);
    send_pattern(4);
  endtask

  task automatic test_overflow_wrap();
    set_vertices(2);
    for (int k = 0; k < 7; k++) send_entry($urandom_range(1) == 1, 1'b0, 0);
    send_matrix(50, 0);
  endtask

  task automatic test_random_graphs();
    int unsigned done;
    done = 0;
    while (done < 780) begin
      set_vertices($urandom_range(99) < 85 ? $urandom_range(5, 1) : $urandom_range(10, 6));
      for (int g = 0; g < 6 && done < 780; g++) begin
        if ($urandom_range(9) == 0)
          send_pattern($urandom_range(5));
        else
          send_matrix($urandom_range(99), 10);
        done += vertices * vertices;
      end
    end
  endtask

  task automatic test_backpressure();
    set_vertices(2);
    stall_mode_random = 1'b0;
    hold_cycles = 400;
    for (int g = 0; g < 6; g++) send_matrix(50, 0);
    wait (hold_cycles == 0);
    stall_mode_random = 1'b1;
    wait_drained();
    send_matrix(60, 0);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (!stall_mode_random && hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else if (tail_phase) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_flags.size() == 0) begin
          $display("%0t: result expected none actual %b", $time, out_item);
          errors++;
        end else begin
          out_item_t exp;
          exp = pending_flags.pop_front();
          if (exp.is_regular !== out_item.is_regular)
            $display("%0t: is_regular expected %b actual %b", $time, exp.is_regular,
                     out_item.is_regular);
          if (exp.is_balanced !== out_item.is_balanced)
            $display("%0t: is_balanced expected %b actual %b", $time, exp.is_balanced,
                     out_item.is_balanced);
          if (exp.is_strongly_connected !== out_item.is_strongly_connected)
            $display("%0t: is_strongly_connected expected %b actual %b", $time,
                     exp.is_strongly_connected, out_item.is_strongly_connected);
          if (exp.is_weakly_connected !== out_item.is_weakly_connected)
            $display("%0t: is_weakly_connected expected %b actual %b", $time,
                     exp.is_weakly_connected, out_item.is_weakly_connected);
          if (exp.is_eulerian !== out_item.is_eulerian)
            $display("%0t: is_eulerian expected %b actual %b", $time, exp.is_eulerian,
                     out_item.is_eulerian);
          if (exp !== out_item) errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < MaxVertices; i++) begin
      graph_rows[i] = '0;
      graph_cols[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow_wrap();
    test_backpressure();
    test_random_graphs();
    tail_phase = 1'b1;
    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
